>>> hdl/kcu_pkg.sv
// shared types, constants and round functions for the keeloq cipher unit
// used by kcu_learn_feed, kcu_round_cell and keeloq_cipher_unit; no dependencies
package kcu_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned KEY_W       = 64;
    localparam int unsigned RESULT_W    = 64;
    localparam int unsigned SERIAL_W    = 28;
    localparam int unsigned ROUND_COUNT = 528;
    localparam int unsigned CELL_ROUNDS = 8;
    localparam int unsigned CELL_COUNT  = ROUND_COUNT / CELL_ROUNDS;

    localparam logic [31:0] NLF_TABLE   = 32'h3A5C742E;
    localparam logic [31:0] SERIAL_MASK = 32'h0FFFFFFF;
    localparam logic [31:0] LEARN_TOP1  = 32'h20000000;
    localparam logic [31:0] LEARN_TOP2  = 32'h60000000;

    typedef enum logic [1:0] {
        OP_ENCRYPT = 2'd0,
        OP_DECRYPT = 2'd1,
        OP_LEARN   = 2'd2
    } t_opcode;

    // what an entry in the chain is and what the output stage does with it
    typedef enum logic [2:0] {
        KIND_ENC    = 3'd0,
        KIND_DEC    = 3'd1,
        KIND_LRN_LO = 3'd2,
        KIND_LRN_HI = 3'd3,
        KIND_NONE   = 3'd4
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_cell_ctl;

    function automatic logic [5:0] enc_key_idx(int r);
        return r[5:0];
    endfunction

    // wraps modulo the key length
    function automatic logic [5:0] dec_key_idx(int r);
        int t;
        t = 15 - r;
        return t[5:0];
    endfunction

    function automatic logic [31:0] enc_round(logic [31:0] v, logic kbit);
        logic fb;
        fb = v[0] ^ v[16] ^ kbit ^ NLF_TABLE[{v[31], v[26], v[20], v[9], v[1]}];
        return {fb, v[31:1]};
    endfunction

    function automatic logic [31:0] dec_round(logic [31:0] v, logic kbit);
        logic fb;
        fb = v[31] ^ v[15] ^ kbit ^ NLF_TABLE[{v[30], v[25], v[19], v[8], v[0]}];
        return {v[30:0], fb};
    endfunction

endpackage

>>> hdl/kcu_round_cell.sv
// one cell of the round chain: eight encrypt or decrypt rounds, then a register
// depends on kcu_pkg
module kcu_round_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [kcu_pkg::KEY_W-1:0]    i_key,
    input  kcu_pkg::t_cell_ctl           i_ctl,
    input  logic [kcu_pkg::WORD_W-1:0]   i_word,
    output kcu_pkg::t_cell_ctl           o_ctl,
    output logic [kcu_pkg::WORD_W-1:0]   o_word
);
    import kcu_pkg::*;

    t_cell_ctl         r_ctl;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        logic [WORD_W-1:0] v;
        logic              dec;
        v   = i_word;
        dec = (i_ctl.kind != KIND_ENC);
        for (int j = 0; j < CELL_ROUNDS; j++) begin
            if (dec) begin
                v = dec_round(v, i_key[dec_key_idx(CELL_INDEX * CELL_ROUNDS + j)]);
            end else begin
                v = enc_round(v, i_key[enc_key_idx(CELL_INDEX * CELL_ROUNDS + j)]);
            end
        end
        n_word = v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{valid: 1'b0, kind: KIND_NONE};
        end else if (i_advance) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_word <= n_word;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_word = r_word;

endmodule

>>> hdl/kcu_learn_feed.sv
// front end of the chain: decodes the opcode and splits learning into two passes
// depends on kcu_pkg
module kcu_learn_feed (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic [kcu_pkg::WORD_W-1:0]   i_data_word,
    output kcu_pkg::t_cell_ctl           o_ctl,
    output logic [kcu_pkg::WORD_W-1:0]   o_word
);
    import kcu_pkg::*;

    logic                r_learn_pend;
    logic [SERIAL_W-1:0] r_serial;
    logic                w_is_learn;

    assign w_is_learn = (t_opcode'(i_opcode) == OP_LEARN);
    assign o_in_ready = i_advance && !r_learn_pend;

    always_comb begin
        if (r_learn_pend) begin
            o_ctl  = '{valid: 1'b1, kind: KIND_LRN_HI};
            o_word = LEARN_TOP2 | {{(WORD_W-SERIAL_W){1'b0}}, r_serial};
        end else begin
            o_ctl.valid = i_in_valid;
            unique case (t_opcode'(i_opcode))
                OP_ENCRYPT: begin
                    o_ctl.kind = KIND_ENC;
                    o_word     = i_data_word;
                end
                OP_DECRYPT: begin
                    o_ctl.kind = KIND_DEC;
                    o_word     = i_data_word;
                end
                OP_LEARN: begin
                    o_ctl.kind = KIND_LRN_LO;
                    o_word     = LEARN_TOP1 | (i_data_word & SERIAL_MASK);
                end
                default: begin
                    o_ctl.kind = KIND_NONE;
                    o_word     = i_data_word;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_pend <= 1'b0;
        end else if (i_advance) begin
            if (r_learn_pend) begin
                r_learn_pend <= 1'b0;
            end else if (i_in_valid && w_is_learn) begin
                r_learn_pend <= 1'b1;
            end
        end
    end

    // second pass of learning reuses the serial of the accepted transaction
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid && w_is_learn) begin
            r_serial <= i_data_word[SERIAL_W-1:0];
        end
    end

endmodule

>>> hdl/keeloq_cipher_unit.sv
// top level of the keeloq cipher unit: key register, round chain, output register
// depends on kcu_pkg, kcu_learn_feed and kcu_round_cell
//
//  port group   direction  handshake                  payload
//  config       in         i_cfg_wr_en                i_cfg_wr_data (64-bit key)
//  input        in         i_in_valid / o_in_ready    i_opcode, i_data_word
//  output       out        o_out_valid / i_out_ready  o_result_word
//
// encrypt and decrypt enter the chain at one transaction per cycle while the chain
// advances; learning occupies two chain entries, one per decryption
// the chain is 66 cells of 8 rounds each; a result passes through every cell register
// and then the output register, and a learning result joins its two passes
// a stalled output register holds the whole chain once its last cell is occupied
// synchronous active-low reset clears the key to zero and empties the chain
module keeloq_cipher_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [kcu_pkg::KEY_W-1:0]      i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_opcode,
    input  logic [kcu_pkg::WORD_W-1:0]     i_data_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [kcu_pkg::RESULT_W-1:0]   o_result_word
);
    import kcu_pkg::*;

    logic [KEY_W-1:0]    r_cipher_key;
    logic                r_out_valid;
    logic [RESULT_W-1:0] r_out_word;
    logic [WORD_W-1:0]   r_learn_lo;
    logic                w_advance;

    t_cell_ctl           w_ctl  [0:CELL_COUNT];
    logic [WORD_W-1:0]   w_word [0:CELL_COUNT];

    t_cell_ctl           w_last;
    logic [WORD_W-1:0]   w_last_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (i_cfg_wr_en) begin
            r_cipher_key <= i_cfg_wr_data;
        end
    end

    kcu_learn_feed u_feed (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_data_word (i_data_word),
        .o_ctl       (w_ctl[0]),
        .o_word      (w_word[0])
    );

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        kcu_round_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_key     (r_cipher_key),
            .i_ctl     (w_ctl[g]),
            .i_word    (w_word[g]),
            .o_ctl     (w_ctl[g+1]),
            .o_word    (w_word[g+1])
        );
    end

    assign w_last      = w_ctl[CELL_COUNT];
    assign w_last_word = w_word[CELL_COUNT];

    // chain moves unless its last cell holds an entry and the output is blocked
    assign w_advance = !w_last.valid || !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_last.valid && (w_last.kind != KIND_LRN_LO)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_last.valid) begin
            case (w_last.kind)
                KIND_ENC, KIND_DEC: r_out_word <= {{(RESULT_W-WORD_W){1'b0}}, w_last_word};
                KIND_LRN_LO:        r_learn_lo <= w_last_word;
                KIND_LRN_HI:        r_out_word <= {w_last_word, r_learn_lo};
                default:            r_out_word <= '0;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_word = r_out_word;

    // the second learning pass always follows the first without a gap
    a_learn_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_last.valid && w_last.kind == KIND_LRN_LO)
        |=> (w_last.valid && w_last.kind == KIND_LRN_HI))
        else $error("learning pass pair split in chain");

    a_ready_needs_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> w_advance)
        else $error("input ready while chain is held");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> ($stable(w_last) && $stable(w_last_word)))
        else $error("chain end moved while output blocked");

endmodule

>>> tb/keeloq_cipher_unit_check.sv
// checker for keeloq_cipher_unit: tracks the key, predicts each result and compares
// depends on kcu_pkg for the opcode names and cipher constants
module keeloq_cipher_unit_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_data_word,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_result_word,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] key_copy;
    logic [63:0] predicted_words[$];
    logic [63:0] want;
    int          fails = 0;

    function automatic logic [31:0] enc_word(logic [31:0] v, logic [63:0] key);
        logic [4:0] sel;
        logic       fb;
        for (int r = 0; r < kcu_pkg::ROUND_COUNT; r++) begin
            sel = {v[31], v[26], v[20], v[9], v[1]};
            fb  = v[0] ^ v[16] ^ key[r % 64] ^ kcu_pkg::NLF_TABLE[sel];
            v   = {fb, v[31:1]};
        end
        return v;
    endfunction

    function automatic logic [31:0] dec_word(logic [31:0] v, logic [63:0] key);
        logic [4:0] sel;
        logic       fb;
        int         key_pos;
        for (int r = 0; r < kcu_pkg::ROUND_COUNT; r++) begin
            // key index runs backwards from 15 and wraps round the 64-bit key
            key_pos = 15 - r;
            sel = {v[30], v[25], v[19], v[8], v[0]};
            fb  = v[31] ^ v[15] ^ key[key_pos[5:0]] ^ kcu_pkg::NLF_TABLE[sel];
            v   = {v[30:0], fb};
        end
        return v;
    endfunction

    function automatic logic [63:0] cipher_result(logic [1:0] op, logic [31:0] word,
                                                  logic [63:0] key);
        logic [31:0] serial;
        serial = word & kcu_pkg::SERIAL_MASK;
        case (op)
            kcu_pkg::OP_ENCRYPT: return {32'h0, enc_word(word, key)};
            kcu_pkg::OP_DECRYPT: return {32'h0, dec_word(word, key)};
            kcu_pkg::OP_LEARN: begin
                return {dec_word(serial | kcu_pkg::LEARN_TOP2, key),
                        dec_word(serial | kcu_pkg::LEARN_TOP1, key)};
            end
            default: return 64'h0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_copy = '0;
            predicted_words.delete();
        end else begin
            if (i_cfg_wr_en) begin
                key_copy = i_cfg_wr_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_words.size() == 0) begin
                    $error("result_word %h arrived with no transaction outstanding",
                           i_result_word);
                    fails++;
                end else begin
                    want = predicted_words.pop_front();
                    if (i_result_word !== want) begin
                        $error("result_word mismatch: expected %h, actual %h",
                               want, i_result_word);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted_words.push_back(cipher_result(i_opcode, i_data_word, key_copy));
            end
        end
        o_pending    <= predicted_words.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/keeloq_cipher_unit_test.sv
// top of the keeloq_cipher_unit testbench: clock, reset, key writes, stimulus, verdict
// depends on kcu_pkg, keeloq_cipher_unit and keeloq_cipher_unit_check
module keeloq_cipher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [63:0] i_cfg_wr_data = '0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_opcode      = kcu_pkg::OP_ENCRYPT;
    logic [31:0] i_data_word   = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [63:0] o_result_word;

    int pending;
    int fail_count;
    int send_idle = 0;
    int recv_idle = 0;
    int key_writes = 0;
    int op_seen[4] = '{0, 0, 0, 0};

    keeloq_cipher_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_data_word  (i_data_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result_word(o_result_word)
    );

    keeloq_cipher_unit_check checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_data_word  (i_data_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_result_word(o_result_word),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] word);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_data_word <= word;
        do @(posedge i_clk); while (!o_in_ready);
        op_seen[op]++;
    endtask

    // every transaction yields a result, so an empty checker queue means idle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_key(input logic [63:0] key);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= key;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        key_writes++;
    endtask

    task automatic run_directed();
        send_item(kcu_pkg::OP_ENCRYPT, 32'h0000_0000);
        send_item(kcu_pkg::OP_ENCRYPT, 32'hFFFF_FFFF);
        send_item(kcu_pkg::OP_DECRYPT, 32'h0000_0000);
        send_item(kcu_pkg::OP_DECRYPT, 32'hFFFF_FFFF);
        send_item(kcu_pkg::OP_LEARN,   32'h0000_0000);
        // upper serial bits must not matter
        send_item(kcu_pkg::OP_LEARN,   32'hFFFF_FFFF);
        send_item(kcu_pkg::OP_LEARN,   32'h0FFF_FFFF);
        send_item(kcu_pkg::OP_LEARN,   32'hF000_0000);
        send_item(OP_UNUSED,           32'h0000_0000);
        send_item(OP_UNUSED,           32'hFFFF_FFFF);
    endtask

    task automatic run_random(input int count);
        logic [1:0]  op;
        logic [31:0] word;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                op = kcu_pkg::OP_ENCRYPT;
            end else if (pick < 60) begin
                op = kcu_pkg::OP_DECRYPT;
            end else if (pick < 94) begin
                op = kcu_pkg::OP_LEARN;
            end else begin
                op = OP_UNUSED;
            end
            case ($urandom_range(0, 9))
                0: word = '0;
                1: word = '1;
                2: word = 32'h1 << $urandom_range(0, 31);
                default: word = $urandom();
            endcase
            send_item(op, word);
        end
    endtask

    initial begin
        send_idle = 28;
        recv_idle = 83;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key first, then the all-ones key
        run_directed();
        wait_drained();
        write_key('1);
        run_directed();
        wait_drained();
        write_key({$urandom(), $urandom()});
        run_random(280);
        wait_drained();

        send_idle = 83;
        recv_idle = 28;
        write_key({$urandom(), $urandom()});
        run_random(280);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        write_key({$urandom(), $urandom()});
        run_random(270);
        wait_drained();

        // allow a stray result to show up after the last expected one
        repeat (80) @(posedge i_clk);

        $display("covered %0d encrypt, %0d decrypt, %0d learning and %0d unused-opcode",
                 op_seen[kcu_pkg::OP_ENCRYPT], op_seen[kcu_pkg::OP_DECRYPT],
                 op_seen[kcu_pkg::OP_LEARN], op_seen[OP_UNUSED]);
        $display("transactions over %0d key writes plus the reset key, %0d failures",
                 key_writes, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
